// ===== rtl/aafp_pkg.sv =====
// ----------------------------------------------------------------------------
// aafp_pkg
// shared types and constants of the add-address frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package aafp_pkg;

    // parse phases of the front end
    typedef enum logic [2:0]
    {
        PH_IDLE  = 3'd0,
        PH_TYPE  = 3'd1,
        PH_FLAGS = 3'd2,
        PH_ID    = 3'd3,
        PH_ADDR  = 3'd4,
        PH_PORT  = 3'd5
    } aafp_phase_t;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_BADVER = 2'd2;

    // flags byte layout
    localparam int unsigned FLAG_PORT_BIT = 4;
    localparam logic [3:0]  VER_IPV4      = 4'd4;
    localparam logic [3:0]  VER_IPV6      = 4'd6;

    // saturation point of the byte counter
    localparam logic [4:0]  COUNT_MAX     = 5'd31;
    // id byte of a frame with a one-byte type field
    localparam logic [4:0]  COUNT_SHORT   = 5'd3;

    // one input request
    typedef struct packed
    {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       buffer_end;
    } aafp_item_t;

    // one result request
    typedef struct packed
    {
        logic [1:0]  status;
        logic [7:0]  addr_id;
        logic [3:0]  ip_version;
        logic        port_present;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [15:0] port;
        logic [4:0]  consumed;
    } aafp_result_t;

    // raw frame record handed from the parser to the back end
    typedef struct packed
    {
        logic [1:0]  status;
        logic [7:0]  addr_id;
        logic [3:0]  ip_version;
        logic        port_present;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] wire_port;
        logic [4:0]  consumed;
    } aafp_record_t;

endpackage

`default_nettype wire

// ===== rtl/aafp_parser.sv =====
// ----------------------------------------------------------------------------
// aafp_parser
// front end: walks the frame one byte per accepted cycle and emits a raw record
// ----------------------------------------------------------------------------
`default_nettype none

module aafp_parser import aafp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire aafp_item_t   item,
    output logic              rec_valid,
    output aafp_record_t      rec
);

    aafp_phase_t phase_reg, phase_next;
    logic [3:0]  left_reg, left_next;
    logic [4:0]  count_reg, count_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  id_reg, id_next;
    logic [63:0] addr_lo_reg, addr_lo_next;
    logic [63:0] addr_hi_reg, addr_hi_next;
    logic [15:0] port_reg, port_next;

    logic        emit;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  ver;
    logic [7:0]  b;

    assign b   = item.data_byte;
    assign ver = flags_reg[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            left_reg    <= '0;
            count_reg   <= '0;
            flags_reg   <= '0;
            id_reg      <= '0;
            addr_lo_reg <= '0;
            addr_hi_reg <= '0;
            port_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            left_reg    <= left_next;
            count_reg   <= count_next;
            flags_reg   <= flags_next;
            id_reg      <= id_next;
            addr_lo_reg <= addr_lo_next;
            addr_hi_reg <= addr_hi_next;
            port_reg    <= port_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        count_next   = count_reg;
        flags_next   = flags_reg;
        id_next      = id_reg;
        addr_lo_next = addr_lo_reg;
        addr_hi_next = addr_hi_reg;
        port_next    = port_reg;
        emit         = 1'b0;
        done         = 1'b0;
        status       = ST_OK;

        if (item.frame_start)
        begin
            // new frame: clear and size the type varint
            flags_next   = '0;
            id_next      = '0;
            addr_lo_next = '0;
            addr_hi_next = '0;
            port_next    = '0;
            count_next   = 5'd1;
            case (b[7:6])
                2'd0:    left_next = 4'd0;
                2'd1:    left_next = 4'd1;
                2'd2:    left_next = 4'd3;
                default: left_next = 4'd7;
            endcase
            phase_next = (left_next == 4'd0) ? PH_FLAGS : PH_TYPE;
            if (item.buffer_end)
            begin
                emit   = 1'b1;
                status = ST_TRUNC;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (count_reg < COUNT_MAX)
            begin
                count_next = count_reg + 5'd1;
            end
            case (phase_reg)
                PH_TYPE:
                begin
                    if (left_reg != 4'd0)
                    begin
                        left_next = left_reg - 4'd1;
                    end
                    if (left_next == 4'd0)
                    begin
                        phase_next = PH_FLAGS;
                    end
                end
                PH_FLAGS:
                begin
                    flags_next = b;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next = b;
                    if (item.buffer_end && (count_next <= COUNT_SHORT))
                    begin
                        emit   = 1'b1;
                        status = ST_TRUNC;
                        done   = 1'b1;
                    end
                    else if (!(ver inside {VER_IPV4, VER_IPV6}))
                    begin
                        emit   = 1'b1;
                        status = ST_BADVER;
                        done   = 1'b1;
                    end
                    else
                    begin
                        // address length minus the byte still to come
                        left_next  = (ver == VER_IPV4) ? 4'd3 : 4'd15;
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    if (ver == VER_IPV6)
                    begin
                        addr_hi_next = {addr_hi_reg[55:0], addr_lo_reg[63:56]};
                    end
                    addr_lo_next = {addr_lo_reg[55:0], b};
                    if (left_reg == 4'd0)
                    begin
                        if (flags_reg[FLAG_PORT_BIT])
                        begin
                            left_next  = 4'd1;
                            phase_next = PH_PORT;
                        end
                        else
                        begin
                            emit = 1'b1;
                            done = 1'b1;
                        end
                    end
                    else
                    begin
                        left_next = left_reg - 4'd1;
                    end
                end
                PH_PORT:
                begin
                    port_next = {port_reg[7:0], b};
                    if (left_reg == 4'd0)
                    begin
                        emit = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        left_next = left_reg - 4'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
            endcase
            if (!done && item.buffer_end)
            begin
                emit   = 1'b1;
                status = ST_TRUNC;
            end
        end

        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    assign rec_valid        = accept && emit;
    assign rec.status       = status;
    assign rec.addr_id      = id_next;
    assign rec.ip_version   = flags_next[3:0];
    assign rec.port_present = flags_next[FLAG_PORT_BIT];
    assign rec.addr_high    = addr_hi_next;
    assign rec.addr_low     = addr_lo_next;
    assign rec.wire_port    = port_next;
    assign rec.consumed     = count_next;

endmodule

`default_nettype wire

// ===== rtl/aafp_queue.sv =====
// ----------------------------------------------------------------------------
// aafp_queue
// short record queue between the parser and the result stage
// ----------------------------------------------------------------------------
`default_nettype none

module aafp_queue import aafp_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire aafp_record_t  wr_data,
    input  wire logic          rd_en,
    output aafp_record_t       rd_data,
    output logic               not_empty,
    output logic               full
);

    localparam int unsigned PTR_W   = $clog2(DEPTH);
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_TOP = COUNT_W'(DEPTH);

    aafp_record_t       mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               do_wr;
    logic               do_rd;

    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign not_empty = count_reg != '0;
    assign full      = count_reg == COUNT_TOP;
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/aafp_formatter.sv =====
// ----------------------------------------------------------------------------
// aafp_formatter
// back end: masks failed frames, fills in the default port, holds the result
// ----------------------------------------------------------------------------
`default_nettype none

module aafp_formatter import aafp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [15:0]   default_port,
    input  wire logic          rec_avail,
    input  wire aafp_record_t  rec,
    output logic               rec_take,
    input  wire logic          pop,
    output logic               empty,
    output aafp_result_t       result
);

    logic         valid_reg;
    aafp_result_t result_reg;
    aafp_result_t result_next;
    logic         load;
    logic         ok;

    assign load     = !valid_reg || pop;
    assign rec_take = load && rec_avail;
    assign ok       = rec.status == ST_OK;

    always_comb
    begin
        result_next.status       = rec.status;
        result_next.addr_id      = rec.addr_id;
        result_next.ip_version   = rec.ip_version;
        result_next.port_present = rec.port_present;
        result_next.address_high = ok ? rec.addr_high : '0;
        result_next.address_low  = ok ? rec.addr_low : '0;
        result_next.port         = !ok ? '0 : (rec.port_present ? rec.wire_port : default_port);
        result_next.consumed     = rec.consumed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= rec_avail;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            result_reg <= result_next;
        end
    end

    assign empty  = !valid_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/add_address_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// add_address_frame_parser_core
// byte-serial parser for add-address frames of the multipath transport
// ----------------------------------------------------------------------------
// One frame byte is taken per clock while push is high, for as long as full stays
// low. A byte flagged frame_start opens a frame; its type varint is skipped,
// then the flags byte, the address id, 4 or 16 address bytes and an optional
// two-byte port are collected. Each frame gives one result (ok, truncated at
// buffer_end, or unknown ip version); its record enters the record queue on
// the edge that takes the byte finishing the frame and, with nothing else
// waiting, moves on into the output register that drives the result ports.
// Bytes after a result are dropped until the next start. The parser feeds a
// QUEUE_DEPTH-entry record queue and a single output register, so full rises
// only once QUEUE_DEPTH + 1 results wait unpopped, and falls again on the
// clock after the next pop. The byte rate is set by the parser's phase
// update, held back only by full. default_port is applied when a result
// enters the output register and is written through the cfg channel, which
// is always ready; write it only while no frame or result is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module add_address_frame_parser_core import aafp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    // byte requests
    input  wire logic          push,
    output logic               full,
    input  wire aafp_item_t    item,

    // result requests
    output logic               empty,
    input  wire logic          pop,
    output aafp_result_t       result,

    // configuration write: default port
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [15:0]   cfg_data
);

    logic [15:0]  default_port_reg;
    logic         accept;
    logic         rec_valid;
    aafp_record_t rec;
    aafp_record_t q_head;
    logic         q_not_empty;
    logic         q_full;
    logic         q_take;

    // config register, no backpressure needed
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_port_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            default_port_reg <= cfg_data;
        end
    end

    // a byte may produce a record, so stall only on a full queue
    assign full   = q_full;
    assign accept = push && !q_full;

    // front: frame walk
    aafp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // decoupling queue
    aafp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_valid),
        .wr_data   (rec),
        .rd_en     (q_take),
        .rd_data   (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // back: result formatting and output register
    aafp_formatter u_formatter
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .default_port (default_port_reg),
        .rec_avail    (q_not_empty),
        .rec          (q_head),
        .rec_take     (q_take),
        .pop          (pop),
        .empty        (empty),
        .result       (result)
    );

endmodule

`default_nettype wire
